[src/fio_pkg.sv]
`timescale 1ns / 1ps

package fio_pkg;

    localparam int NUM_ROUNDS_DEF = 16;
    localparam int HALF_W         = 16;
    localparam int WORD_W         = 32;

    // Only the low half of the LCG matters: the round function keeps the
    // low 16 bits, and those depend only on the low 16 bits of the inputs.
    localparam logic [HALF_W-1:0] LCG_MUL_LO = 16'h660D;   // 1664525 mod 2^16
    localparam logic [HALF_W-1:0] LCG_ADD_LO = 16'hF35F;   // 1013904223 mod 2^16

    localparam logic OP_OBF   = 1'b0;
    localparam logic OP_DEOBF = 1'b1;

    typedef logic [HALF_W-1:0] half_t;

    typedef enum logic {
        KS_IDLE,
        KS_EXPAND
    } ks_state_t;

    typedef struct packed {
        logic busy;
        logic rk_we;
    } ks_ctrl_t;

    function automatic half_t lcg16(input half_t x);
        logic [2*HALF_W-1:0] prod;
        begin
            prod = {{HALF_W{1'b0}}, x} * {{HALF_W{1'b0}}, LCG_MUL_LO};
            return half_t'(prod[HALF_W-1:0] + LCG_ADD_LO);
        end
    endfunction

    function automatic half_t round_f(input half_t k, input half_t r);
        half_t sum;
        begin
            sum = half_t'(k + r);
            return lcg16(sum);
        end
    endfunction

endpackage

[src/fio_keysched.sv]
`timescale 1ns / 1ps

// Round key expansion, one key per cycle.
module fio_keysched #(
    parameter int NUM_ROUNDS = fio_pkg::NUM_ROUNDS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   key_wr,
    input  logic [fio_pkg::HALF_W-1:0]             key_lo,
    output fio_pkg::ks_ctrl_t                      ctrl,
    output logic [NUM_ROUNDS-1:0][fio_pkg::HALF_W-1:0] rks
);

    localparam int IDX_W = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ROUNDS - 1);

    fio_pkg::ks_state_t state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg;
    fio_pkg::half_t     seed_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fio_pkg::KS_IDLE:
            begin
                if (key_wr)
                    state_next = fio_pkg::KS_EXPAND;
            end
            fio_pkg::KS_EXPAND:
            begin
                if (!key_wr && idx_reg == LAST_IDX)
                    state_next = fio_pkg::KS_IDLE;
            end
            default: state_next = fio_pkg::KS_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl.busy  = (state_reg == fio_pkg::KS_EXPAND);
        ctrl.rk_we = (state_reg == fio_pkg::KS_EXPAND) && !key_wr;
    end

    // reset seeds the expansion of key = 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fio_pkg::KS_EXPAND;
            idx_reg   <= '0;
            seed_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (key_wr)
            begin
                idx_reg  <= '0;
                seed_reg <= key_lo;
            end
            else if (state_reg == fio_pkg::KS_EXPAND)
            begin
                idx_reg  <= idx_reg + 1'b1;
                seed_reg <= fio_pkg::lcg16(seed_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rk_we)
            rks[idx_reg] <= seed_reg;
    end

endmodule

[src/feistel_int32_obfuscator.sv]
`timescale 1ns / 1ps

// Feistel word obfuscator. Each request (start high while busy is low)
// carries a 32-bit value and an opcode (0 obfuscate, 1 deobfuscate); the
// value is split into 16-bit halves and run through NUM_ROUNDS Feistel
// rounds, one pipeline stage per round, with an input and an output
// register around them. A new request can be taken every cycle while busy
// is low; its result passes the input register, the round stages and the
// output register and appears on result with done high for exactly one
// cycle, in request order. The receiver cannot stall, so results must be
// taken when done is high. Writing key (key_wr high for one cycle)
// rebuilds the round keys through the LCG step, one key per cycle: busy
// stays high after the write until the last round key is written, and
// likewise after reset, while the keys of key = 0 are built. Only bits
// 15:0 of key affect the transform. Write the key only when no request is
// in flight.
module feistel_int32_obfuscator #(
    parameter int NUM_ROUNDS = fio_pkg::NUM_ROUNDS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       opcode,
    input  logic [fio_pkg::WORD_W-1:0] value,
    output logic                       done,
    output logic [fio_pkg::WORD_W-1:0] result,
    input  logic                       key_wr,
    input  logic [fio_pkg::WORD_W-1:0] key
);

    localparam int HW = fio_pkg::HALF_W;

    fio_pkg::ks_ctrl_t                  ks_ctrl;
    logic [NUM_ROUNDS-1:0][HW-1:0]      rks;

    logic                               accept;
    logic [NUM_ROUNDS:0]                vld_reg;
    logic [NUM_ROUNDS:0]                inv_reg;
    fio_pkg::half_t                     l_reg [NUM_ROUNDS+1];
    fio_pkg::half_t                     r_reg [NUM_ROUNDS+1];
    logic                               done_reg;
    logic [fio_pkg::WORD_W-1:0]         result_reg;

    // key bits 31:16 never reach the low half of the round function
    fio_keysched #(
        .NUM_ROUNDS (NUM_ROUNDS)
    ) u_keysched (
        .clk    (clk),
        .rst_n  (rst_n),
        .key_wr (key_wr),
        .key_lo (key[HW-1:0]),
        .ctrl   (ks_ctrl),
        .rks    (rks)
    );

    assign busy   = ks_ctrl.busy;
    assign accept = start && !busy;

    // valid bits travel alongside the halves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[NUM_ROUNDS-1:0], accept};
            done_reg <= vld_reg[NUM_ROUNDS];
        end
    end

    // input register: upper half is L, lower half is R
    always_ff @(posedge clk)
    begin
        inv_reg[0] <= opcode;
        l_reg[0]   <= value[2*HW-1:HW];
        r_reg[0]   <= value[HW-1:0];
    end

    // one round per stage; deobfuscation walks the keys backward
    for (genvar s = 0; s < NUM_ROUNDS; s++)
    begin : g_round
        fio_pkg::half_t rk_sel;

        assign rk_sel = (inv_reg[s] == fio_pkg::OP_DEOBF) ? rks[NUM_ROUNDS-1-s] : rks[s];

        always_ff @(posedge clk)
        begin
            inv_reg[s+1] <= inv_reg[s];
            l_reg[s+1]   <= r_reg[s];
            r_reg[s+1]   <= l_reg[s] ^ fio_pkg::round_f(rk_sel, r_reg[s]);
        end
    end

    // halves swap on the way out
    always_ff @(posedge clk)
    begin
        result_reg <= {r_reg[NUM_ROUNDS], l_reg[NUM_ROUNDS]};
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(NUM_ROUNDS + 2) done)
        else $error("request did not complete after the pipeline latency");

    a_key_busy: assert property (@(posedge clk) disable iff (!rst_n)
        key_wr |=> busy)
        else $error("key write did not start round key expansion");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> vld_reg == '0 || $past(vld_reg[NUM_ROUNDS]))
        else $error("done raised without a request at the pipeline end");
`endif

endmodule
